/* rtl/utf8_japanese_text_detect_defines.svh */
// ----------------------------------------------------------------------------
// utf8_japanese_text_detect_defines.svh
// Assertion macros shared by the checker files of the text detector.
// ----------------------------------------------------------------------------
`ifndef UTF8_JAPANESE_TEXT_DETECT_DEFINES_SVH
`define UTF8_JAPANESE_TEXT_DETECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UJTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ujtd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UJTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ujtd: next-cycle check failed");

`endif

/* rtl/ujtd_pkg.sv */
// ----------------------------------------------------------------------------
// ujtd_pkg
// Types and constants of the UTF-8 Japanese text detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ujtd_pkg;

    // Code point width (up to U+10FFFF)
    localparam int CP_W = 21;

    // Byte classes of the UTF-8 encoding
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    // Leads whose first continuation has a narrowed range
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_90   = 8'h90;

    // Kana ranges
    localparam logic [CP_W-1:0] HIRA_LO   = 21'h03040;
    localparam logic [CP_W-1:0] KATA_HI   = 21'h030FF;
    localparam logic [CP_W-1:0] KEXT_LO   = 21'h031F0;
    localparam logic [CP_W-1:0] KEXT_HI   = 21'h031FF;
    localparam logic [CP_W-1:0] HWKATA_LO = 21'h0FF66;
    localparam logic [CP_W-1:0] HWKATA_HI = 21'h0FF9F;

    // CJK ideograph ranges
    localparam logic [CP_W-1:0] CJK_LO    = 21'h04E00;
    localparam logic [CP_W-1:0] CJK_HI    = 21'h09FFF;
    localparam logic [CP_W-1:0] CJKA_LO   = 21'h03400;
    localparam logic [CP_W-1:0] CJKA_HI   = 21'h04DBF;
    localparam logic [CP_W-1:0] CJKC_LO   = 21'h0F900;
    localparam logic [CP_W-1:0] CJKC_HI   = 21'h0FAFF;

    // Japanese-specific punctuation
    localparam logic [CP_W-1:0] P_ITER    = 21'h03005;
    localparam logic [CP_W-1:0] P_CLOSE   = 21'h03006;
    localparam logic [CP_W-1:0] P_BRK_LO  = 21'h0300C;
    localparam logic [CP_W-1:0] P_BRK_HI  = 21'h0300F;
    localparam logic [CP_W-1:0] P_WAVE_LO = 21'h0301C;
    localparam logic [CP_W-1:0] P_WAVE_HI = 21'h0301F;
    localparam logic [CP_W-1:0] P_MASU    = 21'h0303B;
    localparam logic [CP_W-1:0] P_DOT     = 21'h030FB;
    localparam logic [CP_W-1:0] P_LONG    = 21'h030FC;
    localparam logic [CP_W-1:0] P_HWLONG  = 21'h0FF70;

    // One input byte
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    // One verdict
    typedef struct packed {
        logic contains_japanese;
        logic saw_kana;
        logic saw_cjk;
        logic saw_punct;
    } out_item_t;

    // Class hits of one code point
    typedef struct packed {
        logic kana;
        logic cjk;
        logic punct;
    } cp_class_t;

endpackage

`default_nettype wire

/* rtl/ujtd_classify.sv */
// ----------------------------------------------------------------------------
// ujtd_classify
// Range compares that sort one code point into kana, CJK and punctuation.
// ----------------------------------------------------------------------------
`default_nettype none

module ujtd_classify
    import ujtd_pkg::*;
(
    input  wire logic [CP_W-1:0] code_point,
    output cp_class_t            cls
);

    logic punct;

    // Punctuation set: a few single points and two short runs
    always_comb
    begin
        punct = 1'b0;
        if ((code_point == P_ITER) || (code_point == P_CLOSE) ||
            (code_point == P_MASU) || (code_point == P_DOT) ||
            (code_point == P_LONG) || (code_point == P_HWLONG))
        begin
            punct = 1'b1;
        end
        if ((code_point >= P_BRK_LO) && (code_point <= P_BRK_HI))
        begin
            punct = 1'b1;
        end
        if ((code_point >= P_WAVE_LO) && (code_point <= P_WAVE_HI))
        begin
            punct = 1'b1;
        end
    end

    // Kana and ideograph ranges
    always_comb
    begin
        cls.kana  = ((code_point >= HIRA_LO)   && (code_point <= KATA_HI))   ||
                    ((code_point >= KEXT_LO)   && (code_point <= KEXT_HI))   ||
                    ((code_point >= HWKATA_LO) && (code_point <= HWKATA_HI));
        cls.cjk   = ((code_point >= CJK_LO)  && (code_point <= CJK_HI))  ||
                    ((code_point >= CJKA_LO) && (code_point <= CJKA_HI)) ||
                    ((code_point >= CJKC_LO) && (code_point <= CJKC_HI));
        cls.punct = punct;
    end

endmodule

`default_nettype wire

/* rtl/utf8_japanese_text_detect.sv */
// ----------------------------------------------------------------------------
// utf8_japanese_text_detect
// Byte-serial validating UTF-8 decoder with a per-text Japanese verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a text enter on the byte channel (byte_valid / byte_stall /
//   byte_data), one per transfer; byte_data.last_byte marks the final byte.
//   Exactly one verdict leaves on the verdict channel for each text, after
//   its last byte; other bytes produce nothing.
//   Path: a last byte passes the input register, then is decoded into the
//   result register, which raises verdict_valid.
//   Throughput: one byte per cycle while byte_stall is low. The decode state
//   update and the range compares sit between the input register and the
//   state and result registers.
//   Receiver stall: the verdict holds in the result register; non-last bytes
//   keep flowing, and only a last byte that finds the result register full
//   and stalled waits, which raises byte_stall.
//   Reset: all decoder state and flags clear, both channels go empty.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_japanese_text_detect
    import ujtd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_data,
    output logic           verdict_valid,
    input  wire logic      verdict_stall,
    output out_item_t      verdict_data
);

    // Input register
    logic               s1_valid_reg;
    in_item_t           s1_item_reg;
    // Decoder state
    logic [1:0]         exp_reg,   exp_next;
    logic [CP_W-1:0]    part_reg,  part_next;
    logic [7:0]         lead_reg,  lead_next;
    logic               kana_reg,  kana_next;
    logic               cjk_reg,   cjk_next;
    logic               punct_reg, punct_next;
    // Result register
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               advance;
    logic [7:0]         b;
    logic               is_cont;
    logic               first_ok;
    logic               done;
    logic [CP_W-1:0]    cp;
    logic [CP_W-1:0]    part_sh;
    logic [1:0]         exp_dec;
    cp_class_t          cls;
    logic               f_kana, f_cjk, f_punct;

    // Flow control: only a last byte can wait for the result register
    assign advance    = s1_valid_reg &&
                        (!s1_item_reg.last_byte || !out_valid_reg || !verdict_stall);
    assign byte_stall = s1_valid_reg && !advance;

    // Input register, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    // Input register, payload
    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            s1_item_reg <= byte_data;
        end
    end

    assign b       = s1_item_reg.byte_value;
    assign is_cont = ((b & CONT_MASK) == CONT_TAG);
    assign part_sh = {part_reg[CP_W-7:0], b[5:0]};
    assign exp_dec = exp_reg - 2'd1;

    // Range rule for the first continuation after a restricted lead
    always_comb
    begin
        case (lead_reg)
            LEAD_E0: first_ok = (b >= CONT_A0);
            LEAD_ED: first_ok = (b <  CONT_A0);
            LEAD_F0: first_ok = (b >= CONT_90);
            LEAD_F4: first_ok = (b <  CONT_90);
            default: first_ok = 1'b1;
        endcase
    end

    // Decoder step
    always_comb
    begin
        exp_next  = exp_reg;
        part_next = part_reg;
        lead_next = lead_reg;
        done      = 1'b0;
        cp        = part_sh;
        if ((exp_reg == 2'd0) || !is_cont)
        begin
            // Fresh start: ASCII, a lead, or a dropped byte
            exp_next  = 2'd0;
            part_next = '0;
            lead_next = '0;
            cp        = {{(CP_W-8){1'b0}}, b};
            if (b < ASCII_LIMIT)
            begin
                done = 1'b1;
            end
            else if (b < LEAD2_MIN)
            begin
                done = 1'b0;
            end
            else if (b < LEAD3_MIN)
            begin
                exp_next  = 2'd1;
                part_next = {{(CP_W-5){1'b0}}, b[4:0]};
                lead_next = b;
            end
            else if (b < LEAD4_MIN)
            begin
                exp_next  = 2'd2;
                part_next = {{(CP_W-4){1'b0}}, b[3:0]};
                lead_next = b;
            end
            else if (b < LEAD_LIMIT)
            begin
                exp_next  = 2'd3;
                part_next = {{(CP_W-3){1'b0}}, b[2:0]};
                lead_next = b;
            end
        end
        else if ((lead_reg != 8'h00) && !first_ok)
        begin
            // Overlong, surrogate or out of range: drop the sequence
            exp_next  = 2'd0;
            part_next = '0;
            lead_next = '0;
        end
        else
        begin
            // Good continuation
            lead_next = '0;
            exp_next  = exp_dec;
            if (exp_dec == 2'd0)
            begin
                done      = 1'b1;
                part_next = '0;
            end
            else
            begin
                part_next = part_sh;
            end
        end
    end

    ujtd_classify u_classify (
        .code_point (cp),
        .cls        (cls)
    );

    // Flag update; a last byte clears everything after the verdict
    always_comb
    begin
        f_kana     = kana_reg  || (done && cls.kana);
        f_cjk      = cjk_reg   || (done && cls.cjk);
        f_punct    = punct_reg || (done && cls.punct);
        kana_next  = f_kana;
        cjk_next   = f_cjk;
        punct_next = f_punct;
        if (s1_item_reg.last_byte)
        begin
            kana_next  = 1'b0;
            cjk_next   = 1'b0;
            punct_next = 1'b0;
        end
    end

    // Decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg   <= 2'd0;
            part_reg  <= '0;
            lead_reg  <= '0;
            kana_reg  <= 1'b0;
            cjk_reg   <= 1'b0;
            punct_reg <= 1'b0;
        end
        else if (advance)
        begin
            kana_reg  <= kana_next;
            cjk_reg   <= cjk_next;
            punct_reg <= punct_next;
            if (s1_item_reg.last_byte)
            begin
                exp_reg  <= 2'd0;
                part_reg <= '0;
                lead_reg <= '0;
            end
            else
            begin
                exp_reg  <= exp_next;
                part_reg <= part_next;
                lead_reg <= lead_next;
            end
        end
    end

    // Result register, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_item_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!verdict_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register, payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_item_reg.last_byte)
        begin
            out_item_reg.contains_japanese <= f_kana || (f_cjk && f_punct);
            out_item_reg.saw_kana          <= f_kana;
            out_item_reg.saw_cjk           <= f_cjk;
            out_item_reg.saw_punct         <= f_punct;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict_data  = out_item_reg;

endmodule

`default_nettype wire

/* rtl/ujtd_checker.sv */
// ----------------------------------------------------------------------------
// ujtd_checker
// Port-level checks of the text detector, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_japanese_text_detect_defines.svh"

module ujtd_checker
    import ujtd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    input  wire logic      byte_stall,
    input  wire in_item_t  byte_data,
    input  wire logic      verdict_valid,
    input  wire logic      verdict_stall,
    input  wire out_item_t verdict_data
);

    // A stalled verdict stays put
    `UJTD_ASSERT_NXT(a_verdict_hold, clk, rst_n, verdict_valid && verdict_stall, verdict_valid && $stable(verdict_data))

    // The verdict bit agrees with the three flags
    `UJTD_ASSERT_IMP(a_verdict_rule, clk, rst_n, verdict_valid, verdict_data.contains_japanese == (verdict_data.saw_kana || (verdict_data.saw_cjk && verdict_data.saw_punct)))

    // Bytes wait only behind a full, stalled result
    `UJTD_ASSERT_IMP(a_stall_cause, clk, rst_n, byte_stall, verdict_valid && verdict_stall)

    // A fresh verdict follows a last-byte transfer through the input and result registers
    `UJTD_ASSERT_IMP(a_verdict_src, clk, rst_n, $rose(verdict_valid), $past(byte_valid && !byte_stall && byte_data.last_byte, 2))

endmodule

bind utf8_japanese_text_detect ujtd_checker u_ujtd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_data     (byte_data),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_data  (verdict_data)
);

`default_nettype wire
